@@ rtl/core/crc8fr_pkg.sv @@
`timescale 1ns / 1ps

package crc8fr_pkg;

   localparam int unsigned MAX_FRAME_LEN = 64;

   localparam logic [7:0] CRC_POLY = 8'hD5;
   localparam logic [7:0] CRC_INIT = 8'h00;
   localparam logic [7:0] RESET_EXPECTED_TYPE = 8'h05;
   localparam logic RESET_TYPE_CHECK_ON = 1'b1;

   // frame status codes
   localparam logic [1:0] ST_GOOD = 2'd0;
   localparam logic [1:0] ST_CRC = 2'd1;
   localparam logic [1:0] ST_TYPE = 2'd2;
   localparam logic [1:0] ST_LEN = 2'd3;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // register indexes
   localparam logic REG_EXPECTED_TYPE = 1'b0;
   localparam logic REG_TYPE_CHECK_ON = 1'b1;

   // byte positions with a fixed meaning
   localparam logic [7:0] POS_LENGTH = 8'd0;
   localparam logic [7:0] POS_TYPE = 8'd1;
   localparam logic [7:0] POS_FIRST_PAYLOAD = 8'd2;
   localparam logic [7:0] MIN_LENGTH = 8'd2;

   typedef struct packed {
      logic [7:0] expected_type;
      logic       type_check_on;
   } cfg_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] payload_byte;
      logic [7:0] frame_kind;
      logic [1:0] frame_status;
      logic [7:0] payload_seen;
   } result_type;

   // MSB-first CRC-8 over one byte, no reflection
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] acc;
      acc = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (acc[7]) begin
            acc = {acc[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            acc = {acc[6:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

@@ rtl/core/crc8fr_if.sv @@
`timescale 1ns / 1ps

interface crc8fr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface crc8fr_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] payload_byte;
   logic [7:0] frame_kind;
   logic [1:0] frame_status;
   logic [7:0] payload_seen;

   modport source (output valid, output result_kind, output payload_byte,
                   output frame_kind, output frame_status, output payload_seen,
                   input ready);
   modport sink (input valid, input result_kind, input payload_byte,
                 input frame_kind, input frame_status, input payload_seen,
                 output ready);
endinterface

@@ rtl/core/crc8fr_parser.sv @@
`timescale 1ns / 1ps

module crc8fr_parser
   import crc8fr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output logic       res_valid,
   output result_type res
);

   logic [7:0] position_ff, position_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] crc_next;

   always_comb begin
      crc_next = crc8_update(crc_ff, rx_byte);
   end

   always_comb begin
      position_in = position_ff;
      length_in = length_ff;
      crc_in = crc_ff;
      type_in = type_ff;
      res_valid = 1'b0;
      res = '0;
      if (accept) begin
         priority if (position_ff == POS_LENGTH) begin
            crc_in = CRC_INIT;
            type_in = 8'd0;
            if (rx_byte < MIN_LENGTH) begin
               // too short to hold a type byte: report and stay put
               length_in = 8'd0;
               res_valid = 1'b1;
               res.result_kind = KIND_STATUS;
               res.frame_status = ST_LEN;
            end else begin
               length_in = rx_byte;
               position_in = POS_TYPE;
            end
         end else if (position_ff == POS_TYPE) begin
            type_in = rx_byte;
            crc_in = crc8_update(CRC_INIT, rx_byte);
            position_in = POS_FIRST_PAYLOAD;
         end else if (position_ff < length_ff) begin
            crc_in = crc_next;
            res_valid = 1'b1;
            res.result_kind = KIND_PAYLOAD;
            res.payload_byte = rx_byte;
            res.frame_kind = type_ff;
            res.frame_status = ST_GOOD;
            res.payload_seen = position_ff - 8'd1;
            position_in = position_ff + 8'd1;
         end else begin
            // CRC word closes the frame
            res_valid = 1'b1;
            res.result_kind = KIND_STATUS;
            res.frame_kind = type_ff;
            res.payload_seen = length_ff - MIN_LENGTH;
            priority if ({24'd0, length_ff} > 32'(MAX_FRAME_LEN)) begin
               res.frame_status = ST_LEN;
            end else if (cfg.type_check_on && (type_ff != cfg.expected_type)) begin
               res.frame_status = ST_TYPE;
            end else if (rx_byte != crc_ff) begin
               res.frame_status = ST_CRC;
            end else begin
               res.frame_status = ST_GOOD;
            end
            position_in = POS_LENGTH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= POS_LENGTH;
         length_ff <= 8'd0;
         crc_ff <= CRC_INIT;
         type_ff <= 8'd0;
      end else begin
         position_ff <= position_in;
         length_ff <= length_in;
         crc_ff <= crc_in;
         type_ff <= type_in;
      end
   end

endmodule

@@ rtl/core/crc8fr_out_buf.sv @@
`timescale 1ns / 1ps

module crc8fr_out_buf
   import crc8fr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  result_type in_data,
   output logic       in_ready,
   crc8fr_rsp_if.source rsp
);

   logic       main_valid_ff, main_valid_in;
   result_type main_data_ff, main_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff, skid_data_in;
   logic       main_free;

   // ready depends only on the skid slot, so it never waits on rsp.ready
   assign in_ready = !skid_valid_ff;
   assign main_free = !main_valid_ff || rsp.ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in = skid_data_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_data_in = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp.valid = main_valid_ff;
   assign rsp.result_kind = main_data_ff.result_kind;
   assign rsp.payload_byte = main_data_ff.payload_byte;
   assign rsp.frame_kind = main_data_ff.frame_kind;
   assign rsp.frame_status = main_data_ff.frame_status;
   assign rsp.payload_seen = main_data_ff.payload_seen;

endmodule

@@ rtl/core/crc8_frame_receiver_unit.sv @@
`timescale 1ns / 1ps
// A word's result is registered in the output buffer (main or skid slot) before it shows on rsp.
// Throughput: one word per cycle while req.ready is high; the CRC byte update is one unrolled stage.
// A two-entry output buffer keeps req.ready high while one result waits on rsp.
// Reset (synchronous, active high) returns to awaiting a length byte, clears the
// CRC and type, empties the output buffer and loads expected_type 5, type check on.

module crc8_frame_receiver_unit
   import crc8fr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   crc8fr_req_if.sink   req,
   crc8fr_rsp_if.source rsp,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data
);

   cfg_type    cfg_ff, cfg_in;
   logic       accept;
   logic       res_valid;
   result_type res;
   logic       buf_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_EXPECTED_TYPE: cfg_in.expected_type = csr_write_data;
            REG_TYPE_CHECK_ON: cfg_in.type_check_on = csr_write_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_type <= RESET_EXPECTED_TYPE;
         cfg_ff.type_check_on <= RESET_TYPE_CHECK_ON;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req.ready = buf_ready;
   assign accept = req.valid && buf_ready;

   crc8fr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req.rx_byte),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   crc8fr_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .in_valid (res_valid),
      .in_data  (res),
      .in_ready (buf_ready),
      .rsp      (rsp)
   );

endmodule
